### sv/prur_pkg.sv
// Shared command and status types for the root-of-unity search block.
`default_nettype none
package prur_pkg;

    localparam int unsigned FIELD_WIDTH = 15;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DIV_PRE,
        CMD_C_INIT,
        CMD_C_INC,
        CMD_POW_N,
        CMD_POW_QUO,
        CMD_POW_I,
        CMD_MUL_AB,
        CMD_MUL_BB,
        CMD_DIV_PROD,
        CMD_WR_ACC,
        CMD_WR_B,
        CMD_I_INIT,
        CMD_I_INC,
        CMD_DIV_NI,
        CMD_RES_FOUND,
        CMD_RES_NONE
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic rem_zero;
        logic e_zero;
        logic e_lsb;
        logic acc_one;
        logic isq_gt_n;
        logic c_ge_q;
        logic n_zero;
        logic q_lt2;
        logic i_eq_n;
    } status_t;

endpackage
`default_nettype wire

### sv/prur_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
`default_nettype none
module prur_div #(
    parameter int unsigned W = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [2*W-1:0] dividend,
    input  wire logic [W-1:0]   divisor,
    output logic                done,
    output logic [2*W-1:0]      quotient,
    output logic [W-1:0]        remainder
);

    localparam int unsigned CW = $clog2(2 * W);

    logic           busy_reg;
    logic           done_reg;
    logic [CW-1:0]  cnt_reg;
    logic [2*W-1:0] dq_reg;
    logic [W-1:0]   rem_reg;
    logic [W-1:0]   div_reg;
    logic [W:0]     trial;
    logic           ge;
    logic [W:0]     diff;

    assign trial = {rem_reg, dq_reg[2*W-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(2 * W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg) begin
            rem_reg <= ge ? diff[W-1:0] : trial[W-1:0];
            dq_reg  <= {dq_reg[2*W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && !done_reg)
        else $error("divider not busy after start");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !start |=> !done_reg)
        else $error("divider done held");
`endif

endmodule
`default_nettype wire

### sv/prur_datapath.sv
// Datapath: operand registers, multiplier, divider and result registers.
`default_nettype none
module prur_datapath #(
    parameter int unsigned W = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [prur_pkg::FIELD_WIDTH-1:0] order,
    input  wire logic [prur_pkg::FIELD_WIDTH-1:0] modulus,
    input  wire prur_pkg::cmd_t               cmd,
    output prur_pkg::status_t                 status,
    output logic [prur_pkg::FIELD_WIDTH-1:0]  root,
    output logic                              found
);

    localparam int unsigned FW = prur_pkg::FIELD_WIDTH;

    logic [W-1:0]   order_v;
    logic [W-1:0]   modulus_v;
    logic [W-1:0]   n_reg;
    logic [W-1:0]   q_reg;
    logic [W-1:0]   c_reg;
    logic [W-1:0]   i_reg;
    logic [W-1:0]   e_reg;
    logic [W-1:0]   acc_reg;
    logic [W-1:0]   b_reg;
    logic [2*W-1:0] prod_reg;
    logic [FW-1:0]  root_reg;
    logic           found_reg;
    logic [FW-1:0]  c_field;
    logic [2*W-1:0] isq;
    logic           div_start;
    logic [2*W-1:0] dividend;
    logic [W-1:0]   divisor;
    logic           div_done;
    logic [2*W-1:0] quotient;
    logic [W-1:0]   remainder;

    if (W >= FW) begin : g_wide
        assign order_v   = W'(order);
        assign modulus_v = W'(modulus);
        assign c_field   = c_reg[FW-1:0];
    end
    else begin : g_narrow
        assign order_v   = order[W-1:0];
        assign modulus_v = modulus[W-1:0];
        assign c_field   = FW'(c_reg);
    end

    always_comb begin
        div_start = 1'b0;
        dividend  = prod_reg;
        divisor   = q_reg;
        unique case (cmd)
            prur_pkg::CMD_DIV_PRE: begin
                div_start = 1'b1;
                dividend  = (2*W)'(q_reg - 1'b1);
                divisor   = n_reg;
            end
            prur_pkg::CMD_DIV_NI: begin
                div_start = 1'b1;
                dividend  = (2*W)'(n_reg);
                divisor   = i_reg;
            end
            prur_pkg::CMD_DIV_PROD: begin
                div_start = 1'b1;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    prur_div #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dividend),
        .divisor   (divisor),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    assign isq = i_reg * i_reg;

    always_ff @(posedge clk) begin
        unique case (cmd)
            prur_pkg::CMD_LOAD: begin
                n_reg <= order_v;
                q_reg <= modulus_v;
            end
            prur_pkg::CMD_C_INIT:  c_reg <= W'(2);
            prur_pkg::CMD_C_INC:   c_reg <= c_reg + 1'b1;
            prur_pkg::CMD_I_INIT:  i_reg <= W'(2);
            prur_pkg::CMD_I_INC:   i_reg <= i_reg + 1'b1;
            prur_pkg::CMD_POW_N: begin
                e_reg   <= n_reg;
                acc_reg <= W'(1);
                b_reg   <= c_reg;
            end
            prur_pkg::CMD_POW_QUO: begin
                e_reg   <= quotient[W-1:0];
                acc_reg <= W'(1);
                b_reg   <= c_reg;
            end
            prur_pkg::CMD_POW_I: begin
                e_reg   <= i_reg;
                acc_reg <= W'(1);
                b_reg   <= c_reg;
            end
            prur_pkg::CMD_MUL_AB:  prod_reg <= acc_reg * b_reg;
            prur_pkg::CMD_MUL_BB:  prod_reg <= b_reg * b_reg;
            prur_pkg::CMD_WR_ACC:  acc_reg <= remainder;
            prur_pkg::CMD_WR_B: begin
                b_reg <= remainder;
                e_reg <= e_reg >> 1;
            end
            prur_pkg::CMD_RES_FOUND: begin
                root_reg  <= c_field;
                found_reg <= 1'b1;
            end
            prur_pkg::CMD_RES_NONE: begin
                root_reg  <= '0;
                found_reg <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign status.div_done = div_done;
    assign status.rem_zero = remainder == '0;
    assign status.e_zero   = e_reg == '0;
    assign status.e_lsb    = e_reg[0];
    assign status.acc_one  = acc_reg == W'(1);
    assign status.isq_gt_n = isq > (2*W)'(n_reg);
    assign status.c_ge_q   = c_reg >= q_reg;
    assign status.n_zero   = n_reg == '0;
    assign status.q_lt2    = q_reg < W'(2);
    assign status.i_eq_n   = i_reg == n_reg;

    assign root  = root_reg;
    assign found = found_reg;

endmodule
`default_nettype wire

### sv/prur_ctrl.sv
// Controller: sequences the candidate, divisor and exponent loops.
`default_nettype none
module prur_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire prur_pkg::status_t status,
    output prur_pkg::cmd_t         cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_PRE, S_PRE_WAIT, S_CAND, S_POW, S_DIVA, S_WAITA, S_MULB,
        S_DIVB, S_WAITB, S_POW_END, S_ILOOP, S_IWAIT, S_INEXT, S_NEXTC,
        S_FIN_F, S_FIN_N
    } state_t;

    typedef enum logic [1:0] {
        PK_N, PK_QUO, PK_I
    } pow_kind_t;

    state_t    state_reg, state_next;
    pow_kind_t kind_reg, kind_next;
    logic      out_valid_reg, out_valid_next;
    logic      out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        cmd            = prur_pkg::CMD_NONE;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd        = prur_pkg::CMD_LOAD;
                    state_next = S_PRE;
                end
            end
            S_PRE: begin
                if (status.n_zero || status.q_lt2) begin
                    state_next = S_FIN_N;
                end
                else begin
                    cmd        = prur_pkg::CMD_DIV_PRE;
                    state_next = S_PRE_WAIT;
                end
            end
            S_PRE_WAIT: begin
                if (status.div_done) begin
                    if (!status.rem_zero) begin
                        state_next = S_FIN_N;
                    end
                    else begin
                        cmd        = prur_pkg::CMD_C_INIT;
                        state_next = S_CAND;
                    end
                end
            end
            S_CAND: begin
                if (status.c_ge_q) begin
                    state_next = S_FIN_N;
                end
                else begin
                    cmd        = prur_pkg::CMD_POW_N;
                    kind_next  = PK_N;
                    state_next = S_POW;
                end
            end
            S_POW: begin
                priority if (status.e_zero) begin
                    state_next = S_POW_END;
                end
                else if (status.e_lsb) begin
                    cmd        = prur_pkg::CMD_MUL_AB;
                    state_next = S_DIVA;
                end
                else begin
                    state_next = S_MULB;
                end
            end
            S_DIVA: begin
                cmd        = prur_pkg::CMD_DIV_PROD;
                state_next = S_WAITA;
            end
            S_WAITA: begin
                if (status.div_done) begin
                    cmd        = prur_pkg::CMD_WR_ACC;
                    state_next = S_MULB;
                end
            end
            S_MULB: begin
                cmd        = prur_pkg::CMD_MUL_BB;
                state_next = S_DIVB;
            end
            S_DIVB: begin
                cmd        = prur_pkg::CMD_DIV_PROD;
                state_next = S_WAITB;
            end
            S_WAITB: begin
                if (status.div_done) begin
                    cmd        = prur_pkg::CMD_WR_B;
                    state_next = S_POW;
                end
            end
            S_POW_END: begin
                unique case (kind_reg)
                    PK_N: begin
                        if (!status.acc_one) begin
                            state_next = S_NEXTC;
                        end
                        else begin
                            cmd        = prur_pkg::CMD_I_INIT;
                            state_next = S_ILOOP;
                        end
                    end
                    PK_QUO: begin
                        priority if (status.acc_one) begin
                            state_next = S_NEXTC;
                        end
                        else if (!status.i_eq_n) begin
                            cmd        = prur_pkg::CMD_POW_I;
                            kind_next  = PK_I;
                            state_next = S_POW;
                        end
                        else begin
                            state_next = S_INEXT;
                        end
                    end
                    default: begin
                        state_next = status.acc_one ? S_NEXTC : S_INEXT;
                    end
                endcase
            end
            S_ILOOP: begin
                if (status.isq_gt_n) begin
                    state_next = S_FIN_F;
                end
                else begin
                    cmd        = prur_pkg::CMD_DIV_NI;
                    state_next = S_IWAIT;
                end
            end
            S_IWAIT: begin
                if (status.div_done) begin
                    if (status.rem_zero) begin
                        // quotient n/i becomes the exponent before the divider is reused
                        cmd        = prur_pkg::CMD_POW_QUO;
                        kind_next  = PK_QUO;
                        state_next = S_POW;
                    end
                    else begin
                        state_next = S_INEXT;
                    end
                end
            end
            S_INEXT: begin
                cmd        = prur_pkg::CMD_I_INC;
                state_next = S_ILOOP;
            end
            S_NEXTC: begin
                cmd        = prur_pkg::CMD_C_INC;
                state_next = S_CAND;
            end
            S_FIN_F: begin
                if (out_free) begin
                    cmd            = prur_pkg::CMD_RES_FOUND;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_FIN_N: begin
                if (out_free) begin
                    cmd            = prur_pkg::CMD_RES_NONE;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            kind_reg      <= PK_N;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == prur_pkg::CMD_RES_FOUND || cmd == prur_pkg::CMD_RES_NONE)
        |-> !(out_valid_reg && out_stall))
        else $error("result overwrites pending transfer");
    a_res_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == prur_pkg::CMD_RES_FOUND || cmd == prur_pkg::CMD_RES_NONE)
        |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result written without valid");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == prur_pkg::CMD_LOAD |=> state_reg == S_PRE)
        else $error("load did not start search");
`endif

endmodule
`default_nettype wire

### sv/primitive_root_of_unity_search.sv
// Top level: primitive n-th root of unity search modulo q.
// Input channel (in_valid/in_stall) transfers order n and modulus q; the
// output channel (out_valid/out_stall) transfers root and found, one result
// per input item. in_stall is low only while the controller is idle, so one
// item is searched at a time. A finished result sits in the output register
// while the next item is taken in; a new result waits only if the previous
// one is still stalled.
// Latency is data dependent. Every modular product is a multiply into the
// product register followed by a shift-subtract division by q; a power c^e
// costs up to two products per exponent bit. Each candidate needs one power
// of n plus up to two powers for each divisor pair found by trial division
// (each trial division uses the same divider). The shared divider sets the
// rate. An item rejected by the n | q-1 test gets its result after that one
// trial division, with no power computed.
// Reset clears the controller and output valid; no clearing pass is needed.
`default_nettype none
module primitive_root_of_unity_search #(
    parameter int unsigned VALUE_WIDTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [prur_pkg::FIELD_WIDTH-1:0] order,
    input  wire logic [prur_pkg::FIELD_WIDTH-1:0] modulus,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [prur_pkg::FIELD_WIDTH-1:0]      root,
    output logic                                  found
);

    prur_pkg::cmd_t    cmd;
    prur_pkg::status_t status;

    prur_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    prur_datapath #(.W(VALUE_WIDTH)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .order   (order),
        .modulus (modulus),
        .cmd     (cmd),
        .status  (status),
        .root    (root),
        .found   (found)
    );

endmodule
`default_nettype wire
